@@ rtl/cgi_pkg.sv @@
package cgi_pkg;

  // Table and gradient limits
  localparam int MAX_BASE_COLORS = 16;
  localparam int MAX_LUT_SIZE    = 4096;

  // Channel layout: index 0 red, 1 green, 2 blue
  localparam int NUM_CH = 3;
  localparam int CH_W   = 8;

  // Field widths fixed by the register map and the item format
  localparam int LUT_SIZE_W   = 13;
  localparam int BASE_COUNT_W = 5;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_IDX_W    = 1;
  localparam int LUT_IDX_W    = 12;

  // Derived widths
  localparam int ADDR_W = $clog2(MAX_BASE_COLORS);
  localparam int DEN_W  = $clog2(MAX_LUT_SIZE);
  localparam int P_W    = DEN_W + ADDR_W;
  localparam int NUM_W  = DEN_W + CH_W;
  localparam int RGB_W  = NUM_CH * CH_W;

  // Register reset values
  localparam int LUT_SIZE_RST   = 256;
  localparam int BASE_COUNT_RST = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LUT_SIZE   = 1'b0,
    REG_BASE_COUNT = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_QUERY = 1'b1
  } kind_t;

  typedef logic [CH_W-1:0] chan_t;
  typedef chan_t [NUM_CH-1:0] rgb_t;

endpackage

@@ rtl/cgi_ram.sv @@
module cgi_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Two registered read ports, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

@@ rtl/colormap_gradient_interpolator_unit.sv @@
// Piecewise-linear color gradient lookup. Load requests (kind 0) write one
// RGB key color into a 16-entry key table; query requests (kind 1) return
// the color of gradient entry lut_index out of lut_size entries spread evenly
// over the first base_count keys, using exact integer interpolation with a
// floor. The pipeline accepts one request every cycle while the output is
// not stalled. A query's result is formed by these stages in order: one
// stage forms the scaled index, four restoring-division stages find the key
// segment, one stage reads the two neighboring keys from the table RAM,
// two stages form the weighted sum, and eight restoring-division stages
// produce the 8-bit channels, the last of which is the output register.
// Loads use the first five stages and write the table at the read stage, so
// every query sees exactly the loads that came before it. Stages advance
// independently, so bubbles are squeezed out behind a stalled output.
// Configuration writes are taken every cycle and take effect at once in every
// stage, so write them only while no request is in flight.
module colormap_gradient_interpolator_unit
  import cgi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_kind,
  input  logic [ADDR_W-1:0]     in_base_index,
  input  logic [CH_W-1:0]       in_key_red,
  input  logic [CH_W-1:0]       in_key_green,
  input  logic [CH_W-1:0]       in_key_blue,
  input  logic [LUT_IDX_W-1:0]  in_lut_index,

  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CH_W-1:0]       out_red,
  output logic [CH_W-1:0]       out_green,
  output logic [CH_W-1:0]       out_blue,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int NF = ADDR_W + 1;  // front stages: scale plus segment division
  localparam int NQ = CH_W;        // channel division stages

  typedef struct packed {
    kind_t             kind;
    logic [ADDR_W-1:0] base_index;
    rgb_t              key;
    logic [P_W-1:0]    rem;
    logic [ADDR_W-1:0] seg;
  } front_t;

  // ---------------------------------------------------------------------
  // Configuration: keep den = lut_size-1 and base_count-1, both clamped
  // ---------------------------------------------------------------------
  logic [DEN_W-1:0]        den_r;
  logic [ADDR_W-1:0]       keys_m1_r;
  logic [LUT_SIZE_W-1:0]   cfg_lut;
  logic [BASE_COUNT_W-1:0] cfg_bc;

  assign cfg_ready = 1'b1;
  assign cfg_lut   = cfg_data[LUT_SIZE_W-1:0];
  assign cfg_bc    = cfg_data[BASE_COUNT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      den_r     <= DEN_W'(LUT_SIZE_RST - 1);
      keys_m1_r <= ADDR_W'(BASE_COUNT_RST - 1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_LUT_SIZE: begin
          if (cfg_lut < LUT_SIZE_W'(2)) begin
            den_r <= DEN_W'(1);
          end else if (cfg_lut > LUT_SIZE_W'(MAX_LUT_SIZE)) begin
            den_r <= DEN_W'(MAX_LUT_SIZE - 1);
          end else begin
            den_r <= DEN_W'(cfg_lut - LUT_SIZE_W'(1));
          end
        end
        REG_BASE_COUNT: begin
          if (cfg_bc == '0) begin
            keys_m1_r <= '0;
          end else if (cfg_bc > BASE_COUNT_W'(MAX_BASE_COLORS)) begin
            keys_m1_r <= ADDR_W'(MAX_BASE_COLORS - 1);
          end else begin
            keys_m1_r <= ADDR_W'(cfg_bc - BASE_COUNT_W'(1));
          end
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Front stages: scaled index, then one segment bit per stage
  // ---------------------------------------------------------------------
  logic   f_v_r   [NF];
  front_t f_r     [NF];
  front_t f_nxt   [NF];
  logic   f_rdy   [NF];
  logic   r_rdy;

  logic [LUT_IDX_W-1:0] idx_sat;
  logic [P_W-1:0]       den_shift;

  always_comb begin
    // Saturate the index and scale by base_count-1
    idx_sat = (in_lut_index > den_r) ? den_r : in_lut_index;
    f_nxt[0].kind       = kind_t'(in_kind);
    f_nxt[0].base_index = in_base_index;
    f_nxt[0].key        = {in_key_blue, in_key_green, in_key_red};
    f_nxt[0].rem        = {{ADDR_W{1'b0}}, idx_sat} * {{DEN_W{1'b0}}, keys_m1_r};
    f_nxt[0].seg        = '0;
    den_shift           = '0;
    // Restoring division by den, top segment bit first
    for (int f = 1; f < NF; f++) begin
      f_nxt[f]  = f_r[f-1];
      den_shift = P_W'(den_r) << (ADDR_W - f);
      if (f_r[f-1].rem >= den_shift) begin
        f_nxt[f].rem             = f_r[f-1].rem - den_shift;
        f_nxt[f].seg[ADDR_W - f] = 1'b1;
      end
    end
  end

  // Advance each stage when its successor frees up; loads leave at the end
  always_comb begin
    f_rdy[NF-1] = !f_v_r[NF-1] || (f_r[NF-1].kind == KIND_LOAD) || r_rdy;
    for (int f = NF - 2; f >= 0; f--) begin
      f_rdy[f] = !f_v_r[f] || f_rdy[f+1];
    end
  end

  assign in_ready = f_rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int f = 0; f < NF; f++) begin
        f_v_r[f] <= 1'b0;
      end
    end else begin
      if (f_rdy[0]) begin
        f_v_r[0] <= in_valid;
      end
      for (int f = 1; f < NF; f++) begin
        if (f_rdy[f]) begin
          f_v_r[f] <= f_v_r[f-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int f = 0; f < NF; f++) begin
      if (f_rdy[f]) begin
        f_r[f] <= f_nxt[f];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Key table: loads write, queries read keys seg and seg+1
  // ---------------------------------------------------------------------
  logic              tbl_we;
  logic              tbl_re;
  logic [RGB_W-1:0]  key_a;
  logic [RGB_W-1:0]  key_b;
  logic              last_seg;
  logic              r_v_r;
  logic [DEN_W-1:0]  r_rem_r;

  assign tbl_we   = f_v_r[NF-1] && (f_r[NF-1].kind == KIND_LOAD);
  assign tbl_re   = f_v_r[NF-1] && (f_r[NF-1].kind == KIND_QUERY) && r_rdy;
  assign last_seg = (f_r[NF-1].seg >= keys_m1_r);

  // The last entry reads key seg on both ports, so no key past it is touched
  cgi_ram #(
    .WIDTH (RGB_W),
    .DEPTH (MAX_BASE_COLORS)
  ) u_key_ram (
    .clk     (clk),
    .we      (tbl_we),
    .waddr   (f_r[NF-1].base_index),
    .wdata   (f_r[NF-1].key),
    .re      (tbl_re),
    .raddr_a (f_r[NF-1].seg),
    .raddr_b (last_seg ? f_r[NF-1].seg : f_r[NF-1].seg + ADDR_W'(1)),
    .rdata_a (key_a),
    .rdata_b (key_b)
  );

  // Table stage: the last entry weighs key seg alone
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_v_r <= 1'b0;
    end else if (r_rdy) begin
      r_v_r <= tbl_re;
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_re) begin
      r_rem_r <= last_seg ? '0 : f_r[NF-1].rem[DEN_W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Weighted sum a*(den-rem) + b*rem per channel
  // ---------------------------------------------------------------------
  logic             m_v_r;
  logic             m_rdy;
  logic [NUM_W-1:0] prod_a_r [NUM_CH];
  logic [NUM_W-1:0] prod_b_r [NUM_CH];
  logic             n_v_r;
  logic             n_rdy;
  logic [NUM_W-1:0] num_r    [NUM_CH];
  rgb_t             rgb_a;
  rgb_t             rgb_b;
  logic [DEN_W-1:0] wgt_a;

  assign rgb_a = key_a;
  assign rgb_b = key_b;
  assign wgt_a = den_r - r_rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
      n_v_r <= 1'b0;
    end else begin
      if (m_rdy) begin
        m_v_r <= r_v_r;
      end
      if (n_rdy) begin
        n_v_r <= m_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < NUM_CH; c++) begin
      if (m_rdy) begin
        prod_a_r[c] <= NUM_W'(rgb_a[c]) * NUM_W'(wgt_a);
        prod_b_r[c] <= NUM_W'(rgb_b[c]) * NUM_W'(r_rem_r);
      end
      if (n_rdy) begin
        num_r[c] <= prod_a_r[c] + prod_b_r[c];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Channel division by den, one quotient bit per stage
  // ---------------------------------------------------------------------
  logic             q_v_r     [NQ];
  logic             q_rdy     [NQ];
  logic [NUM_W-1:0] q_rem_r   [NQ][NUM_CH];
  chan_t            q_quo_r   [NQ][NUM_CH];
  logic [NUM_W-1:0] q_rem_nxt [NQ][NUM_CH];
  chan_t            q_quo_nxt [NQ][NUM_CH];
  logic [NUM_W-1:0] num_shift;

  always_comb begin
    num_shift = '0;
    for (int k = 0; k < NQ; k++) begin
      num_shift = NUM_W'(den_r) << (CH_W - 1 - k);
      for (int c = 0; c < NUM_CH; c++) begin
        if (k == 0) begin
          q_rem_nxt[k][c] = num_r[c];
          q_quo_nxt[k][c] = '0;
        end else begin
          q_rem_nxt[k][c] = q_rem_r[k-1][c];
          q_quo_nxt[k][c] = q_quo_r[k-1][c];
        end
        if (q_rem_nxt[k][c] >= num_shift) begin
          q_rem_nxt[k][c]              = q_rem_nxt[k][c] - num_shift;
          q_quo_nxt[k][c][CH_W - 1 - k] = 1'b1;
        end
      end
    end
  end

  // Back-end ready chain from the output register
  always_comb begin
    q_rdy[NQ-1] = !q_v_r[NQ-1] || out_ready;
    for (int k = NQ - 2; k >= 0; k--) begin
      q_rdy[k] = !q_v_r[k] || q_rdy[k+1];
    end
  end

  assign n_rdy = !n_v_r || q_rdy[0];
  assign m_rdy = !m_v_r || n_rdy;
  assign r_rdy = !r_v_r || m_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NQ; k++) begin
        q_v_r[k] <= 1'b0;
      end
    end else begin
      if (q_rdy[0]) begin
        q_v_r[0] <= n_v_r;
      end
      for (int k = 1; k < NQ; k++) begin
        if (q_rdy[k]) begin
          q_v_r[k] <= q_v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NQ; k++) begin
      if (q_rdy[k]) begin
        for (int c = 0; c < NUM_CH; c++) begin
          q_rem_r[k][c] <= q_rem_nxt[k][c];
          q_quo_r[k][c] <= q_quo_nxt[k][c];
        end
      end
    end
  end

  // Last division stage is the output register
  assign out_valid = q_v_r[NQ-1];
  assign out_red   = q_quo_r[NQ-1][0];
  assign out_green = q_quo_r[NQ-1][1];
  assign out_blue  = q_quo_r[NQ-1][2];

endmodule

@@ dv/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cgi_pkg::*;

  localparam int HOLD_OFF     = 24;    // pipeline depth plus margin before a register write
  localparam int WATCHDOG     = 2000;  // cycles without any handshake before giving up
  localparam int NUM_PHASES   = 10;
  localparam int PHASE_ITEMS  = 172;
  localparam int NUM_FIXED_PH = 6;
  localparam int NUM_ROWS     = 25;

  // One directed request; the expected color is filled in only where it is obvious
  typedef struct packed {
    kind_t                 kind;
    logic [ADDR_W-1:0]     slot;
    chan_t                 red;
    chan_t                 green;
    chan_t                 blue;
    logic [LUT_IDX_W-1:0]  idx;
    logic                  fixed;
    chan_t                 exp_red;
    chan_t                 exp_green;
    chan_t                 exp_blue;
  } stim_row_t;

  // Reset settings: lut_size 256, base_count 9, so den 255 and entry 255 is key 8
  localparam stim_row_t DIRECTED [NUM_ROWS] = '{
    '{KIND_LOAD,  4'd0,  8'h00, 8'h00, 8'h00, 12'd0,    1'b0, 8'h00, 8'h00, 8'h00},
    '{KIND_LOAD,  4'd1,  8'hFF, 8'hFF, 8'hFF, 12'd0,    1'b0, 8'h00, 8'h00, 8'h00},
    '{KIND_LOAD,  4'd2,  8'hAA, 8'h55, 8'hAA, 12'd0,    1'b0, 8'h00, 8'h00, 8'h00},
    '{KIND_LOAD,  4'd3,  8'h55, 8'hAA, 8'h55, 12'd0,    1'b0, 8'h00, 8'h00, 8'h00},
    '{KIND_LOAD,  4'd4,  8'h80, 8'h40, 8'h20, 12'd0,    1'b0, 8'h00, 8'h00, 8'h00},
    '{KIND_LOAD,  4'd5,  8'h01, 8'h02, 8'h04, 12'd0,    1'b0, 8'h00, 8'h00, 8'h00},
    '{KIND_LOAD,  4'd6,  8'h7F, 8'hFE, 8'h3C, 12'd0,    1'b0, 8'h00, 8'h00, 8'h00},
    '{KIND_LOAD,  4'd7,  8'hC3, 8'h18, 8'hE7, 12'd0,    1'b0, 8'h00, 8'h00, 8'h00},
    '{KIND_LOAD,  4'd8,  8'h12, 8'h34, 8'h56, 12'd0,    1'b0, 8'h00, 8'h00, 8'h00},
    '{KIND_LOAD,  4'd9,  8'h9A, 8'hBC, 8'hDE, 12'd0,    1'b0, 8'h00, 8'h00, 8'h00},
    '{KIND_LOAD,  4'd10, 8'hFF, 8'h00, 8'h80, 12'd0,    1'b0, 8'h00, 8'h00, 8'h00},
    '{KIND_LOAD,  4'd11, 8'h00, 8'hFF, 8'h7F, 12'd0,    1'b0, 8'h00, 8'h00, 8'h00},
    '{KIND_LOAD,  4'd12, 8'h3E, 8'h6D, 8'h91, 12'd0,    1'b0, 8'h00, 8'h00, 8'h00},
    '{KIND_LOAD,  4'd13, 8'hF0, 8'h0F, 8'h5A, 12'd0,    1'b0, 8'h00, 8'h00, 8'h00},
    '{KIND_LOAD,  4'd14, 8'h21, 8'h43, 8'h65, 12'd0,    1'b0, 8'h00, 8'h00, 8'h00},
    '{KIND_LOAD,  4'd15, 8'hED, 8'hCB, 8'hA9, 12'd0,    1'b0, 8'h00, 8'h00, 8'h00},
    '{KIND_QUERY, 4'd0,  8'h00, 8'h00, 8'h00, 12'd0,    1'b1, 8'h00, 8'h00, 8'h00},
    '{KIND_QUERY, 4'd0,  8'h00, 8'h00, 8'h00, 12'd255,  1'b1, 8'h12, 8'h34, 8'h56},
    '{KIND_QUERY, 4'd0,  8'h00, 8'h00, 8'h00, 12'd4095, 1'b1, 8'h12, 8'h34, 8'h56},
    '{KIND_QUERY, 4'd0,  8'h00, 8'h00, 8'h00, 12'd256,  1'b1, 8'h12, 8'h34, 8'h56},
    '{KIND_QUERY, 4'd0,  8'h00, 8'h00, 8'h00, 12'd1,    1'b0, 8'h00, 8'h00, 8'h00},
    '{KIND_QUERY, 4'd0,  8'h00, 8'h00, 8'h00, 12'd32,   1'b0, 8'h00, 8'h00, 8'h00},
    '{KIND_QUERY, 4'd0,  8'h00, 8'h00, 8'h00, 12'd128,  1'b0, 8'h00, 8'h00, 8'h00},
    '{KIND_LOAD,  4'd0,  8'hFF, 8'hFF, 8'hFF, 12'd0,    1'b0, 8'h00, 8'h00, 8'h00},
    '{KIND_QUERY, 4'd0,  8'h00, 8'h00, 8'h00, 12'd0,    1'b1, 8'hFF, 8'hFF, 8'hFF}
  };

  // Register settings of the fixed phases: extremes and out-of-range values
  localparam logic [CFG_DATA_W-1:0] PH_LUT  [NUM_FIXED_PH] =
    '{13'd2, 13'd8191, 13'd0, 13'd1, 13'd4096, 13'd4097};
  localparam logic [CFG_DATA_W-1:0] PH_BASE [NUM_FIXED_PH] =
    '{13'd2, 13'd31, 13'd0, 13'd16, 13'd1, 13'd17};

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_kind = 1'b0;
  logic [ADDR_W-1:0]     in_base_index = '0;
  logic [CH_W-1:0]       in_key_red = '0;
  logic [CH_W-1:0]       in_key_green = '0;
  logic [CH_W-1:0]       in_key_blue = '0;
  logic [LUT_IDX_W-1:0]  in_lut_index = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [CH_W-1:0]       out_red;
  logic [CH_W-1:0]       out_green;
  logic [CH_W-1:0]       out_blue;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor state: shadow registers and key table
  logic [LUT_SIZE_W-1:0]   lut_size_q = LUT_SIZE_W'(LUT_SIZE_RST);
  logic [BASE_COUNT_W-1:0] base_count_q = BASE_COUNT_W'(BASE_COUNT_RST);
  rgb_t                    key_tab [MAX_BASE_COLORS];
  rgb_t                    pending_colors [$];

  // Typed expectation for the request on the bus, if any
  logic        row_fixed = 1'b0;
  rgb_t        row_color = '0;

  int unsigned mismatch_cnt = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_left = 0;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;

  colormap_gradient_interpolator_unit i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_base_index (in_base_index),
    .in_key_red    (in_key_red),
    .in_key_green  (in_key_green),
    .in_key_blue   (in_key_blue),
    .in_lut_index  (in_lut_index),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Clamp the gradient size and key count to what the block supports
  function automatic int unsigned eff_lut_size();
    if (lut_size_q < 2) return 2;
    if (lut_size_q > MAX_LUT_SIZE) return MAX_LUT_SIZE;
    return 32'(lut_size_q);
  endfunction

  function automatic int unsigned eff_key_count();
    if (base_count_q < 1) return 1;
    if (base_count_q > MAX_BASE_COLORS) return MAX_BASE_COLORS;
    return 32'(base_count_q);
  endfunction

  // Interpolate between the two keys around the requested entry, floored
  function automatic rgb_t gradient_color(logic [LUT_IDX_W-1:0] idx);
    int unsigned den, keys, pos, scaled, seg, rem, lo, hi, ch;
    rgb_t        color;
    den  = eff_lut_size() - 1;
    keys = eff_key_count();
    pos  = 32'(idx);
    if (pos > den) pos = den;
    scaled = pos * (keys - 1);
    seg    = scaled / den;
    rem    = scaled % den;
    if (seg >= keys) seg = keys - 1;
    for (ch = 0; ch < NUM_CH; ch++) begin
      lo = 32'(key_tab[seg][ch]);
      if (seg + 1 < keys) begin
        hi = 32'(key_tab[seg + 1][ch]);
        color[ch] = chan_t'((lo * (den - rem) + hi * rem) / den);
      end else begin
        color[ch] = chan_t'(lo);
      end
    end
    return color;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic note_failure(string what);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("%0t: %s", $realtime, what);
  endtask

  // Track requests, configuration and results at each rising edge
  always @(posedge clk) begin
    rgb_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_colors.size() == 0) begin
          note_failure($sformatf("result %h %h %h with no query waiting",
                                 out_red, out_green, out_blue));
        end else begin
          want = pending_colors.pop_front();
          if (out_red !== want[0] || out_green !== want[1] || out_blue !== want[2])
            note_failure($sformatf("color mismatch: expected r=%h g=%h b=%h, got r=%h g=%h b=%h",
                                   want[0], want[1], want[2], out_red, out_green, out_blue));
        end
      end
      if (in_valid && in_ready) begin
        if (in_kind == KIND_QUERY)
          pending_colors.push_back(row_fixed ? row_color : gradient_color(in_lut_index));
        else
          key_tab[in_base_index] = {in_key_blue, in_key_green, in_key_red};
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_LUT_SIZE)
          lut_size_q = cfg_data[LUT_SIZE_W-1:0];
        else
          base_count_q = cfg_data[BASE_COUNT_W-1:0];
      end
    end
  end

  // Stall the result channel at random
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_ready = 1'b0;
      stall_left--;
    end else begin
      out_ready = 1'b1;
      if (!rx_calm) stall_left = pick_gap();
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Present one request and hold it until accepted
  task automatic send_request(kind_t kind, logic [ADDR_W-1:0] slot, chan_t red, chan_t green,
                              chan_t blue, logic [LUT_IDX_W-1:0] idx, logic fixed,
                              rgb_t color);
    @(negedge clk);
    in_valid      = 1'b1;
    in_kind       = kind;
    in_base_index = slot;
    in_key_red    = red;
    in_key_green  = green;
    in_key_blue   = blue;
    in_lut_index  = idx;
    row_fixed     = fixed;
    row_color     = color;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic hold_idle(int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
  endtask

  // Drop valid and wait until every query has been answered
  task automatic wait_answers();
    hold_idle(1);
    while (pending_colors.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Mostly queries, some key loads; indexes mostly inside the gradient
  task automatic send_random_request();
    int unsigned r, top;
    chan_t       red, green, blue;
    logic [LUT_IDX_W-1:0] idx;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      red   = chan_t'($urandom());
      green = chan_t'($urandom());
      blue  = chan_t'($urandom());
      if ($urandom_range(0, 9) == 0) begin
        red   = '1;
        green = '0;
        blue  = $urandom_range(0, 1) ? '1 : '0;
      end
      send_request(KIND_LOAD, ADDR_W'($urandom_range(0, MAX_BASE_COLORS - 1)), red, green,
                   blue, LUT_IDX_W'($urandom()), 1'b0, '0);
    end else begin
      top = eff_lut_size() - 1;
      r   = $urandom_range(0, 99);
      if (r < 70)
        idx = LUT_IDX_W'($urandom_range(0, top));
      else if (r < 80)
        idx = $urandom_range(0, 1) ? LUT_IDX_W'(top) : '0;
      else
        idx = LUT_IDX_W'($urandom_range(0, (1 << LUT_IDX_W) - 1));
      send_request(KIND_QUERY, ADDR_W'($urandom()), chan_t'($urandom()), chan_t'($urandom()),
                   chan_t'($urandom()), idx, 1'b0, '0);
    end
  endtask

  initial begin
    int unsigned ph, n;
    logic [CFG_DATA_W-1:0] lut_val, base_val;
    stim_row_t row;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table: load every key first so no query reads an unwritten key
    for (n = 0; n < NUM_ROWS; n++) begin
      row = DIRECTED[n];
      send_request(row.kind, row.slot, row.red, row.green, row.blue, row.idx, row.fixed,
                   {row.exp_blue, row.exp_green, row.exp_red});
      hold_idle(pick_gap());
    end

    // Random phases, each under its own register setting
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      wait_answers();
      repeat (HOLD_OFF) @(posedge clk);
      if (ph < NUM_FIXED_PH) begin
        lut_val  = PH_LUT[ph];
        base_val = PH_BASE[ph];
      end else begin
        lut_val  = CFG_DATA_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191)
                                                            : $urandom_range(2, 64));
        base_val = {8'($urandom()), 5'($urandom_range(0, 31))};
      end
      write_reg(REG_LUT_SIZE, lut_val);
      write_reg(REG_BASE_COUNT, base_val);
      tx_calm = (ph % 3 == 1);
      rx_calm = (ph % 4 == 2);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        send_random_request();
        // Hold the sender until the pipeline has emptied
        if (n == PHASE_ITEMS / 2 && ph % 2 == 0) wait_answers();
        if (!tx_calm) hold_idle(pick_gap());
      end
    end

    wait_answers();
    repeat (40) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
